[sv/rpmg_pkg.sv]
// ----------------------------------------------------------------------------
// rpmg_pkg - shared definitions for the rotated pixel map generator
// Register indexes, field widths and fixed-point constants.
// ----------------------------------------------------------------------------
package rpmg_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR   = 3'd7;

    // field widths
    localparam int TRIG_W  = 18;
    localparam int SIDE_W  = 11;
    localparam int PIVOT_W = 12;
    localparam int SIZE_W  = 12;
    localparam int INDEX_W = 24;
    localparam int COORD_W = 14;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;

    // reset and limits
    localparam logic signed [TRIG_W-1:0] COS_RESET = 18'sd65536;
    localparam int MAX_SIDE_DEF = 1024;
    localparam logic [SIZE_W-1:0] SIZE_CAP = 12'd4095;
    // half a pixel plus the ceiling bias, in 16.16
    localparam logic [31:0] ROUND_BIAS = 32'd98303;

endpackage

[sv/rotated_pixel_map_generator.sv]
// ----------------------------------------------------------------------------
// rotated_pixel_map_generator - inverse rotation pixel map address generator
// Walks the rotated bounding image row by row and gives, for each
// destination pixel, its column-major index and its floored source x,y.
// ----------------------------------------------------------------------------
// Usage:
//   s channel: one transaction per pixel request; tdata bit 0 is start_req.
//     A start computes the bounding size from the registers and emits pixel
//     (0,0); any other transaction steps to the next pixel, wrapping at the end.
//   m channel: one transaction per request, in order; tlast marks the final
//     pixel of the map.
//   cfg port: write-only; change registers only while no request is in flight.
// Timing:
//   one request per clock sustained while the receiver keeps tready high; a
//   result passes the counter stage, the multiplier stage and the output register.
//   The size products of the config registers are kept registered, so a
//   start does not stall the stream.
// Reset: synchronous, active low; registers return to their defaults, the map
//   size to 1 by 1 and the pixel counters to zero; no result is pending.
// Stall: when the receiver holds tready low the pipeline holds in place and
//   s tready drops once all stages are full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rotated_pixel_map_generator #(
    parameter int MAX_SIDE = rpmg_pkg::MAX_SIDE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [rpmg_pkg::S_TDATA_W-1:0]     i_s_tdata,   // [0] start_req
    // master stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [23:0] dest_index, [37:24] src_x, [51:38] src_y,
    // [63:52] new_width, [75:64] new_height, [79:76] zero
    output logic [rpmg_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tlast,   // last_pixel
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [rpmg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rpmg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SW = rpmg_pkg::SIDE_W;
    localparam int ZW = rpmg_pkg::SIZE_W;
    localparam int TW = rpmg_pkg::TRIG_W;
    localparam int PW = rpmg_pkg::PIVOT_W;
    localparam int CW = rpmg_pkg::COORD_W;
    localparam int FB = rpmg_pkg::FRAC_BITS;
    localparam logic [12:0]   MaxSideV  = 13'(MAX_SIDE);
    localparam logic [SW-1:0] SideClamp = (MAX_SIDE > 2047) ? 11'd2047 : 11'(MAX_SIDE);
    localparam logic signed [15:0] CoordMin = -16'sd8192;
    localparam logic signed [15:0] CoordMax = 16'sd8191;

    // clamp a source side to 1..MAX_SIDE
    function automatic logic [SW-1:0] eff_side(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        if (v == '0) begin
            r = 11'd1;
        end else if ({2'b00, v} > MaxSideV) begin
            r = SideClamp;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // rounded extent of a 16.16 value, capped to the size range
    function automatic logic [ZW-1:0] round_cap(input logic signed [30:0] s);
        logic [30:0] mag;
        logic [31:0] sum;
        logic [ZW-1:0] r;
        mag = s[30] ? 31'(-s) : 31'(s);
        sum = {1'b0, mag} + rpmg_pkg::ROUND_BIAS;
        if (sum[31:FB] > {4'b0000, rpmg_pkg::SIZE_CAP}) begin
            r = rpmg_pkg::SIZE_CAP;
        end else begin
            r = sum[FB+ZW-1:FB];
        end
        return r;
    endfunction

    // configuration registers
    logic signed [TW-1:0] r_cos, r_sin, n_cos, n_sin;
    logic [SW-1:0]        r_w, r_h, n_w, n_h;
    logic signed [PW-1:0] r_px, r_py, n_px, n_py;
    logic                 r_explicit, r_mirror, n_explicit, n_mirror;

    // registered products of the configuration
    logic [SW-1:0]        r_w_eff, r_h_eff, n_w_eff, n_h_eff;
    logic signed [29:0]   r_pwc, r_phs, r_pws, r_phc;
    logic signed [CW-1:0] r_px_eff, n_px_eff;

    // map state
    logic [ZW-1:0] r_ow, r_oh, r_col, r_row;
    logic [ZW-1:0] n_ow, n_oh, n_col, n_row;

    // pipeline stages
    logic          r_a_vld, r_b_vld, r_o_vld;
    logic [ZW-1:0] r_a_col, r_a_row, r_a_ow, r_a_oh;
    logic signed [30:0] r_b_xc, r_b_ys, r_b_xs, r_b_yc;
    logic [rpmg_pkg::INDEX_W-1:0] r_b_cidx;
    logic [ZW-1:0] r_b_row, r_b_ow, r_b_oh;
    logic          r_b_last;
    logic [rpmg_pkg::M_TDATA_W-1:0] r_o_data;
    logic          r_o_last;

    logic out_en, b_en, a_en, s_accept;

    // handshake and stage enables
    assign out_en     = !r_o_vld || i_m_tready;
    assign b_en       = !r_b_vld || out_en;
    assign a_en       = !r_a_vld || b_en;
    assign o_s_tready = a_en;
    assign s_accept   = i_s_tvalid && a_en;

    // next configuration values
    always_comb begin
        n_cos      = r_cos;
        n_sin      = r_sin;
        n_w        = r_w;
        n_h        = r_h;
        n_px       = r_px;
        n_py       = r_py;
        n_explicit = r_explicit;
        n_mirror   = r_mirror;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                rpmg_pkg::REG_COS:      n_cos      = $signed(i_cfg_data[TW-1:0]);
                rpmg_pkg::REG_SIN:      n_sin      = $signed(i_cfg_data[TW-1:0]);
                rpmg_pkg::REG_WIDTH:    n_w        = i_cfg_data[SW-1:0];
                rpmg_pkg::REG_HEIGHT:   n_h        = i_cfg_data[SW-1:0];
                rpmg_pkg::REG_PIVOT_X:  n_px       = $signed(i_cfg_data[PW-1:0]);
                rpmg_pkg::REG_PIVOT_Y:  n_py       = $signed(i_cfg_data[PW-1:0]);
                rpmg_pkg::REG_EXPLICIT: n_explicit = i_cfg_data[0];
                rpmg_pkg::REG_MIRROR:   n_mirror   = i_cfg_data[0];
                default: ;
            endcase
        end
        n_w_eff  = eff_side(n_w);
        n_h_eff  = eff_side(n_h);
        n_px_eff = n_mirror ? CW'($signed({3'b000, n_w_eff}) - $signed({{2{n_px[PW-1]}}, n_px}))
                            : CW'(n_px);
    end

    // config registers and their products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos      <= rpmg_pkg::COS_RESET;
            r_sin      <= '0;
            r_w        <= 11'd1;
            r_h        <= 11'd1;
            r_px       <= '0;
            r_py       <= '0;
            r_explicit <= 1'b0;
            r_mirror   <= 1'b0;
            r_w_eff    <= 11'd1;
            r_h_eff    <= 11'd1;
            r_pwc      <= 30'(rpmg_pkg::COS_RESET);
            r_phs      <= '0;
            r_pws      <= '0;
            r_phc      <= 30'(rpmg_pkg::COS_RESET);
            r_px_eff   <= '0;
        end else begin
            r_cos      <= n_cos;
            r_sin      <= n_sin;
            r_w        <= n_w;
            r_h        <= n_h;
            r_px       <= n_px;
            r_py       <= n_py;
            r_explicit <= n_explicit;
            r_mirror   <= n_mirror;
            r_w_eff    <= n_w_eff;
            r_h_eff    <= n_h_eff;
            r_pwc      <= 30'($signed({1'b0, n_w_eff})) * 30'(n_cos);
            r_phs      <= 30'($signed({1'b0, n_h_eff})) * 30'(n_sin);
            r_pws      <= 30'($signed({1'b0, n_w_eff})) * 30'(n_sin);
            r_phc      <= 30'($signed({1'b0, n_h_eff})) * 30'(n_cos);
            r_px_eff   <= n_px_eff;
        end
    end

    // bounding size and pixel counters for an accepted transaction
    always_comb begin
        logic [12:0]   ew, eh;
        logic [ZW-1:0] w1, w2, h1, h2, nw, nh;
        ew = {2'b00, r_w_eff} + {1'b0, r_h_eff, 1'b0};
        eh = {2'b00, r_h_eff} + {1'b0, r_w_eff, 1'b0};
        w1 = round_cap(31'(r_pwc) - 31'(r_phs));
        w2 = round_cap(31'(r_pwc) + 31'(r_phs));
        h1 = round_cap(31'(r_pws) + 31'(r_phc));
        h2 = round_cap(31'(r_phc) - 31'(r_pws));
        nw = {1'b0, r_w_eff};
        if (w1 > nw) nw = w1;
        if (w2 > nw) nw = w2;
        nh = {1'b0, r_h_eff};
        if (h1 > nh) nh = h1;
        if (h2 > nh) nh = h2;
        n_ow  = r_ow;
        n_oh  = r_oh;
        n_col = r_col;
        n_row = r_row;
        if (i_s_tdata[0]) begin
            if (r_explicit) begin
                n_ow = ew[12] ? rpmg_pkg::SIZE_CAP : ew[ZW-1:0];
                n_oh = eh[12] ? rpmg_pkg::SIZE_CAP : eh[ZW-1:0];
            end else begin
                n_ow = nw;
                n_oh = nh;
            end
            n_col = '0;
            n_row = '0;
        end else if (ZW'(r_col + 12'd1) == r_ow) begin
            n_col = '0;
            n_row = (ZW'(r_row + 12'd1) == r_oh) ? '0 : ZW'(r_row + 12'd1);
        end else begin
            n_col = ZW'(r_col + 12'd1);
        end
    end

    // map state and counter stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow    <= 12'd1;
            r_oh    <= 12'd1;
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
        end else begin
            if (s_accept) begin
                r_ow  <= n_ow;
                r_oh  <= n_oh;
                r_col <= n_col;
                r_row <= n_row;
            end
            if (a_en) begin
                r_a_vld <= s_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_col <= n_col;
            r_a_row <= n_row;
            r_a_ow  <= n_ow;
            r_a_oh  <= n_oh;
        end
    end

    // offsets from the image center
    logic signed [12:0] dxr, dyr;
    assign dxr = $signed({1'b0, r_a_col}) - $signed({2'b00, r_a_ow[ZW-1:1]});
    assign dyr = $signed({1'b0, r_a_row}) - $signed({2'b00, r_a_oh[ZW-1:1]});

    // multiplier stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && r_a_vld) begin
            r_b_xc   <= 31'(dxr) * 31'(r_cos);
            r_b_ys   <= 31'(dyr) * 31'(r_sin);
            r_b_xs   <= 31'(dxr) * 31'(r_sin);
            r_b_yc   <= 31'(dyr) * 31'(r_cos);
            r_b_cidx <= rpmg_pkg::INDEX_W'(r_a_col) * rpmg_pkg::INDEX_W'(r_a_oh);
            r_b_row  <= r_a_row;
            r_b_ow   <= r_a_ow;
            r_b_oh   <= r_a_oh;
            r_b_last <= (ZW'(r_a_col + 12'd1) == r_a_ow) && (ZW'(r_a_row + 12'd1) == r_a_oh);
        end
    end

    // source coordinates, floored and saturated
    logic signed [31:0] sum_x, sum_y;
    logic signed [15:0] fx, fy;
    logic [CW-1:0]      sx, sy;
    logic [rpmg_pkg::INDEX_W-1:0] dest;

    assign sum_x = 32'(r_b_xc) + 32'(r_b_ys) + 32'($signed({r_px_eff, 16'b0}));
    assign sum_y = 32'(r_b_yc) - 32'(r_b_xs) + 32'($signed({r_py, 16'b0}));
    assign fx    = sum_x[31:FB];
    assign fy    = sum_y[31:FB];
    assign sx    = (fx < CoordMin) ? CW'(CoordMin) : (fx > CoordMax) ? CW'(CoordMax) : fx[CW-1:0];
    assign sy    = (fy < CoordMin) ? CW'(CoordMin) : (fy > CoordMax) ? CW'(CoordMax) : fy[CW-1:0];
    assign dest  = r_b_cidx + {12'd0, r_b_row};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_en) begin
            r_o_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_b_vld) begin
            r_o_data <= {4'b0000, r_b_oh, r_b_ow, sy, sx, dest};
            r_o_last <= r_b_last;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule
